// File: rtl/core/pbp_pkg.sv
// Shared constants and types for the perceptron branch predictor.
`default_nettype none
package pbp_pkg;
	localparam int ROWS_DEF   = 400;
	localparam int WPR_DEF    = 36;
	localparam int LIMIT_DEF  = 127;
	localparam int PC_W       = 32;
	localparam int WGT_W      = 8;
	localparam int THR_W      = 13;
	localparam int DOT_W      = 14;
	localparam logic [THR_W-1:0] THR_RESET = 13'd83;

	typedef struct packed {
		logic clr;
		logic train;
		logic taken;
	} pbp_ctl_t;
endpackage
`default_nettype wire

// File: rtl/core/pbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 400,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: rtl/core/pbp_cell.sv
// One weight column: its RAM, the add/subtract stage of the sum chain and training.
`default_nettype none
module pbp_cell import pbp_pkg::*; #(
	parameter int ROWS    = ROWS_DEF,
	parameter int LIMIT   = LIMIT_DEF,
	parameter int SW      = 14,
	parameter bit IS_BIAS = 1'b0,
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire pbp_ctl_t             ctl,
	input  wire logic [RW-1:0]        waddr,
	input  wire logic [RW-1:0]        raddr,
	input  wire logic                 hbit,
	input  wire logic signed [SW-1:0] sum_in,
	input  wire logic                 vld_in,
	output logic signed [SW-1:0]      sum_out,
	output logic                      vld_out
);
	localparam logic signed [WGT_W-1:0] PLIM = WGT_W'(LIMIT);
	localparam logic signed [WGT_W-1:0] NLIM = -PLIM;

	logic [WGT_W-1:0]          rdata;
	logic signed [WGT_W-1:0]   w;
	logic signed [SW-1:0]      wx;
	logic signed [WGT_W-1:0]   w_new;
	logic                      up;
	logic signed [SW-1:0]      sum_q;
	logic                      vld_q;

	pbp_ram #(.WIDTH(WGT_W), .DEPTH(ROWS)) u_ram (
		.clk   (clk),
		.we    (ctl.clr | ctl.train),
		.waddr (waddr),
		.wdata (ctl.clr ? '0 : w_new),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		w  = signed'(rdata);
		wx = {{(SW-WGT_W){w[WGT_W-1]}}, w};
		up = IS_BIAS ? ctl.taken : (hbit == ctl.taken);
		if (up) begin
			w_new = (w >= PLIM) ? PLIM : w + WGT_W'(1);
		end else begin
			w_new = (w <= NLIM) ? NLIM : w - WGT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (IS_BIAS || hbit) begin
			sum_q <= sum_in + wx;
		end else begin
			sum_q <= sum_in - wx;
		end
	end

	assign sum_out = sum_q;
	assign vld_out = vld_q;
endmodule
`default_nettype wire

// File: rtl/core/perceptron_branch_predictor.sv
// Top level: control, row modulo unit, history and the chain of weight cells.
//
// Channel  Dir  Signals                     Content
// s_       in   s_tvalid/s_tready/s_tdata   predict or update request, tuser = func
// m_       out  m_tvalid/m_tready/m_tdata   prediction, dot_sum, trained
// cfg_     in   cfg_we/cfg_wdata            train_threshold
//
// The row comes from a reciprocal multiply registered at acceptance and a
// remainder step; then a RAM read, the pass through the cell chain, a capture
// and a decide step. s_tready rises together with the result valid, so a new
// request is not taken until the last one has left the decide step.
// After reset a clearing pass over every row zeroes the weights first.
// A new request is taken while a result waits; the decide cycle holds until
// the output register is free.
`default_nettype none
module perceptron_branch_predictor import pbp_pkg::*; #(
	parameter int ROWS            = ROWS_DEF,
	parameter int WEIGHTS_PER_ROW = WPR_DEF,
	parameter int WEIGHT_LIMIT    = LIMIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [39:0]      s_tdata,  // pc[31:0], taken[32], predicted[33], zeros
	input  wire logic             s_tuser,  // func
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [15:0]           m_tdata,  // prediction[0], dot_sum[14:1], trained[15]
	input  wire logic             cfg_we,
	input  wire logic [THR_W-1:0] cfg_wdata
);
	localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int RL  = (ROWS > 1) ? $clog2(ROWS) : 0;
	localparam int MSH = PC_W + RL;
	localparam int W   = WEIGHTS_PER_ROW;
	localparam int H   = W - 1;
	localparam int SW0 = $clog2(W * WEIGHT_LIMIT + 1) + 1;
	localparam int SW  = (SW0 > DOT_W) ? SW0 : DOT_W;
	localparam logic [PC_W:0] RECIP =
		(PC_W+1)'(((64'd1 << MSH) + 64'(ROWS) - 64'd1) / 64'(ROWS));
	localparam logic [RW-1:0] ROWS_LO = RW'(ROWS);
	localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_SUM  = 3'd4;
	localparam logic [2:0] ST_DEC  = 3'd5;

	logic [2:0]           state_q;
	logic [THR_W-1:0]     thr_q;
	logic [H-1:0]         hist_q;
	logic                 func_q, taken_q, pred_q;
	logic [RW-1:0]        pc_q;
	logic [RW-1:0]        quo_q;
	logic [RW-1:0]        row_q;
	logic [RW-1:0]        clr_q;
	logic                 start_q;
	logic signed [SW-1:0] sum_q;
	logic                 m_tvalid_q;
	logic [15:0]          m_tdata_q;

	logic [2*PC_W:0]      prod;
	logic [RW-1:0]        rem;
	logic                 out_free;
	logic [SW-1:0]        mag;
	logic                 train;
	pbp_ctl_t             ctl;
	logic [RW-1:0]        waddr;

	logic signed [SW-1:0] sum_ch [W+1];
	logic                 vld_ch [W+1];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		prod  = {{(PC_W+1){1'b0}}, s_tdata[PC_W-1:0]} * {{PC_W{1'b0}}, RECIP};
		rem   = pc_q - quo_q * ROWS_LO;
		mag   = sum_q[SW-1] ? -sum_q : sum_q;
		train = func_q && ((taken_q != pred_q) || (mag <= SW'(thr_q)));
		ctl.clr   = (state_q == ST_CLR);
		ctl.train = (state_q == ST_DEC) && out_free && train;
		ctl.taken = taken_q;
		waddr     = ctl.clr ? clr_q : row_q;
	end

	assign sum_ch[0] = '0;
	assign vld_ch[0] = start_q;

	for (genvar g = 0; g < W; g++) begin : g_cell
		pbp_cell #(
			.ROWS    (ROWS),
			.LIMIT   (WEIGHT_LIMIT),
			.SW      (SW),
			.IS_BIAS (g == 0)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.waddr   (waddr),
			.raddr   (row_q),
			.hbit    ((g == 0) ? 1'b1 : hist_q[(g == 0) ? 0 : W-1-g]),
			.sum_in  (sum_ch[g]),
			.vld_in  (vld_ch[g]),
			.sum_out (sum_ch[g+1]),
			.vld_out (vld_ch[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			thr_q      <= THR_RESET;
			hist_q     <= '1;
			clr_q      <= '0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				thr_q <= cfg_wdata;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + RW'(1);
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					state_q <= ST_RD;
				end
				ST_RD: begin
					start_q <= 1'b1;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (vld_ch[W]) begin
						state_q <= ST_DEC;
					end
				end
				ST_DEC: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						if (func_q) begin
							hist_q <= H'({hist_q, taken_q});
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			pc_q    <= s_tdata[RW-1:0];
			quo_q   <= prod[MSH +: RW];
			taken_q <= s_tdata[32];
			pred_q  <= s_tdata[33];
			func_q  <= s_tuser;
		end else if (state_q == ST_MOD) begin
			row_q <= rem;
		end
		if (state_q == ST_SUM && vld_ch[W]) begin
			sum_q <= sum_ch[W];
		end
		if (state_q == ST_DEC && out_free) begin
			m_tdata_q <= {train, sum_q[DOT_W-1:0], !sum_q[SW-1]};
		end
	end
endmodule
`default_nettype wire

// File: rtl/core/pbp_checker.sv
// Port-level assertions for the perceptron branch predictor, bound to the top level.
`default_nettype none
module pbp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_pred_sign: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == !m_tdata[14]))
		else $error("prediction disagrees with sum sign");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");
endmodule

bind perceptron_branch_predictor pbp_checker u_pbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
